>>> rtl/core/ptts_pkg.sv
// ----------------------------------------------------------------------------
// ptts_pkg
// shared types, widths and helpers of the per-symbol trade tick statistics
// ----------------------------------------------------------------------------
package ptts_pkg;

   localparam int SYM_W               = 6;
   localparam int PRICE_W             = 32;
   localparam int SIZE_W              = 24;
   localparam int VOL_W               = 48;
   localparam int CNT_W               = 32;
   localparam int CFG_W               = 7;
   localparam int REQ_W               = 64;
   localparam int REQ_USER_W          = 2;
   localparam int RSP_W               = 200;
   localparam int DEFAULT_NUM_SYMBOLS = 64;

   localparam logic [CFG_W-1:0] SYMBOLS_IN_USE_RESET = CFG_W'(64);

   localparam logic CMD_TRADE  = 1'b0;
   localparam logic CMD_REPORT = 1'b1;

   localparam int USER_CMD_BIT  = 0;
   localparam int USER_SKIP_BIT = 1;

   typedef struct packed {
      logic [VOL_W-1:0]   volume;
      logic [VOL_W-1:0]   tick_volume;
      logic [CNT_W-1:0]   trade_count;
      logic [CNT_W-1:0]   tick_count;
      logic [CNT_W-1:0]   reversals;
      logic [PRICE_W-1:0] last_price;
      logic [PRICE_W-1:0] prior_price;
      logic               down;
   } entry_type;

   typedef struct packed {
      logic             en;
      logic [SYM_W-1:0] addr;
      entry_type        data;
   } wr_type;

   function automatic logic [VOL_W-1:0] sat_add_vol(input logic [VOL_W-1:0] a,
                                                    input logic [SIZE_W-1:0] b);
      logic [VOL_W:0] s;
      s = {1'b0, a} + (VOL_W+1)'(b);
      return s[VOL_W] ? {VOL_W{1'b1}} : s[VOL_W-1:0];
   endfunction

   function automatic logic [CNT_W-1:0] sat_inc_cnt(input logic [CNT_W-1:0] a);
      return (a == {CNT_W{1'b1}}) ? a : a + CNT_W'(1);
   endfunction

endpackage

>>> rtl/core/ptts_update.sv
// ----------------------------------------------------------------------------
// ptts_update
// read-modify-write update of one table entry for a trade
// ----------------------------------------------------------------------------
module ptts_update (
   input  ptts_pkg::entry_type            cur,
   input  logic [ptts_pkg::PRICE_W-1:0]   price,
   input  logic [ptts_pkg::SIZE_W-1:0]    size,
   output ptts_pkg::entry_type            nxt
);
   import ptts_pkg::*;

   logic             first;
   logic             tick;
   logic             down;
   logic [CNT_W-1:0] trade_cnt;
   logic [CNT_W-1:0] tick_cnt;

   always_comb begin
      nxt             = cur;
      trade_cnt       = sat_inc_cnt(cur.trade_count);
      first           = (trade_cnt == CNT_W'(1));
      tick            = first || (price != cur.last_price);
      tick_cnt        = tick ? sat_inc_cnt(cur.tick_count) : cur.tick_count;
      nxt.volume      = sat_add_vol(cur.volume, size);
      nxt.trade_count = trade_cnt;
      nxt.tick_count  = tick_cnt;
      if (tick) begin
         nxt.tick_volume = sat_add_vol(cur.tick_volume, size);
         nxt.last_price  = price;
      end
      if (tick && !first) begin
         nxt.prior_price = cur.last_price;
      end
      down = nxt.last_price < nxt.prior_price;
      if (tick_cnt == CNT_W'(2)) begin
         nxt.down = down;
      end else if (tick_cnt > CNT_W'(2) && cur.down != down) begin
         nxt.down      = down;
         nxt.reversals = sat_inc_cnt(cur.reversals);
      end
   end

endmodule

>>> rtl/core/ptts_table.sv
// ----------------------------------------------------------------------------
// ptts_table
// statistics memory with per-entry valid bits and write-to-read forwarding
// ----------------------------------------------------------------------------
module ptts_table #(
   parameter int NUM_SYMBOLS = ptts_pkg::DEFAULT_NUM_SYMBOLS
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        rd_en,
   input  logic [ptts_pkg::SYM_W-1:0]  rd_addr,
   output ptts_pkg::entry_type         rd_data,
   input  ptts_pkg::wr_type            wr
);
   import ptts_pkg::*;

   localparam int ADDR_W = (NUM_SYMBOLS > 1) ? $clog2(NUM_SYMBOLS) : 1;

   entry_type                mem [0:NUM_SYMBOLS-1];
   logic [NUM_SYMBOLS-1:0]   valid_ff;
   entry_type                mem_q_ff;
   entry_type                fwd_data_ff;
   logic                     fwd_ff;
   logic                     rd_valid_ff;
   logic                     fwd_in;

   assign fwd_in = wr.en && (wr.addr[ADDR_W-1:0] == rd_addr[ADDR_W-1:0]);

   always_ff @(posedge clock) begin
      if (wr.en) begin
         mem[wr.addr[ADDR_W-1:0]] <= wr.data;
      end
      if (rd_en) begin
         mem_q_ff    <= mem[rd_addr[ADDR_W-1:0]];
         fwd_data_ff <= wr.data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff    <= '0;
         fwd_ff      <= 1'b0;
         rd_valid_ff <= 1'b0;
      end else begin
         if (wr.en) begin
            valid_ff[wr.addr[ADDR_W-1:0]] <= 1'b1;
         end
         if (rd_en) begin
            fwd_ff      <= fwd_in;
            rd_valid_ff <= valid_ff[rd_addr[ADDR_W-1:0]];
         end
      end
   end

   assign rd_data = fwd_ff      ? fwd_data_ff :
                    rd_valid_ff ? mem_q_ff    : '0;

endmodule

>>> rtl/core/per_symbol_trade_tick_stats_top.sv
// ----------------------------------------------------------------------------
// per_symbol_trade_tick_stats_top
// per-symbol trade volume, tick and reversal statistics with windowed reports
// ----------------------------------------------------------------------------
// req channel: one item is a trade or a report command (tuser bit 0). a trade
//   names a table entry, price and size; tuser bit 1 marks a skipped trade.
//   trades are taken one per cycle while no report runs; the entry is read
//   from the statistics memory, updated and written back the next cycle,
//   with forwarding so a trade may follow on the same entry straight away.
// a report walks entries 0 to min(symbols_in_use, NUM_SYMBOLS)-1. each entry
//   takes one memory read in ST_READ, then ST_LOAD loads the rsp register and
//   writes the entry back with its volumes and trade and tick counts cleared.
//   req_tready is low for the walk; the first result appears once the walk has
//   passed ST_READ and ST_LOAD into the rsp register; the last has rsp_tlast.
// rsp is held in an output register; a stalled receiver pauses the walk. the
//   next item is taken while the final result still waits.
// csr channel writes symbols_in_use; always ready, write only while idle.
// reset: synchronous, clears the valid bits so every entry reads as zero at
//   once, symbols_in_use returns to 64, no clearing pass.
// ----------------------------------------------------------------------------
module per_symbol_trade_tick_stats_top #(
   parameter int NUM_SYMBOLS = ptts_pkg::DEFAULT_NUM_SYMBOLS
) (
   input  logic                             clock,
   input  logic                             reset,
   // symbol_index, trade_price, share count, zero fill
   input  logic [ptts_pkg::REQ_W-1:0]       req_tdata,
   // command, skip_trade
   input  logic [ptts_pkg::REQ_USER_W-1:0]  req_tuser,
   input  logic                             req_tvalid,
   output logic                             req_tready,
   // report_symbol, window_volume, tick_volume, window_trades, tick_trades,
   // reversal_total, zero fill
   output logic [ptts_pkg::RSP_W-1:0]       rsp_tdata,
   output logic                             rsp_tlast,
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   input  logic [ptts_pkg::CFG_W-1:0]       csr_data,
   input  logic                             csr_valid,
   output logic                             csr_ready
);
   import ptts_pkg::*;

   localparam logic [CFG_W-1:0] NUM_LIM = CFG_W'(NUM_SYMBOLS);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_READ,
      ST_LOAD
   } state_type;

   state_type            state_ff, state_in;
   logic [CFG_W-1:0]     symbols_in_use_ff, symbols_in_use_in;
   logic [CFG_W-1:0]     walk_ff, walk_in;
   logic                 s1_trade_ff, s1_trade_in;
   logic [SYM_W-1:0]     s1_addr_ff, s1_addr_in;
   logic [PRICE_W-1:0]   s1_price_ff, s1_price_in;
   logic [SIZE_W-1:0]    s1_size_ff, s1_size_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic                 rsp_last_ff, rsp_last_in;
   logic [RSP_W-1:0]     rsp_data_ff, rsp_data_in;

   logic                 req_acc;
   logic                 trade_go;
   logic                 report_go;
   logic                 rsp_free;
   logic                 walk_last;
   logic [CFG_W-1:0]     walk_n;
   logic [CFG_W-1:0]     walk_next;
   logic                 rd_en;
   logic [SYM_W-1:0]     rd_addr;
   entry_type            rd_data;
   entry_type            upd_data;
   entry_type            clr_data;
   wr_type               wr;

   ptts_table #(
      .NUM_SYMBOLS (NUM_SYMBOLS)
   ) u_table (
      .clock   (clock),
      .reset   (reset),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data),
      .wr      (wr)
   );

   ptts_update u_update (
      .cur   (rd_data),
      .price (s1_price_ff),
      .size  (s1_size_ff),
      .nxt   (upd_data)
   );

   assign req_tready = (state_ff == ST_IDLE);
   assign csr_ready  = 1'b1;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tlast  = rsp_last_ff;

   assign req_acc   = req_tvalid && req_tready;
   assign trade_go  = req_acc && (req_tuser[USER_CMD_BIT] == CMD_TRADE)
                      && !req_tuser[USER_SKIP_BIT]
                      && ({1'b0, req_tdata[SYM_W-1:0]} < NUM_LIM);
   assign report_go = req_acc && (req_tuser[USER_CMD_BIT] == CMD_REPORT);
   assign rsp_free  = !rsp_valid_ff || rsp_tready;
   assign walk_n    = (symbols_in_use_ff > NUM_LIM) ? NUM_LIM : symbols_in_use_ff;
   assign walk_next = walk_ff + CFG_W'(1);
   assign walk_last = (walk_next == walk_n);

   always_comb begin
      rd_en   = trade_go || ((state_ff == ST_READ) && rsp_free);
      rd_addr = (state_ff == ST_IDLE) ? req_tdata[SYM_W-1:0] : walk_ff[SYM_W-1:0];

      clr_data             = rd_data;
      clr_data.volume      = '0;
      clr_data.tick_volume = '0;
      clr_data.trade_count = '0;
      clr_data.tick_count  = '0;

      wr.en   = s1_trade_ff || (state_ff == ST_LOAD);
      wr.addr = (state_ff == ST_LOAD) ? walk_ff[SYM_W-1:0] : s1_addr_ff;
      wr.data = (state_ff == ST_LOAD) ? clr_data : upd_data;
   end

   always_comb begin
      state_in          = state_ff;
      walk_in           = walk_ff;
      symbols_in_use_in = csr_valid ? csr_data : symbols_in_use_ff;
      s1_trade_in       = trade_go;
      s1_addr_in        = trade_go ? req_tdata[SYM_W-1:0] : s1_addr_ff;
      s1_price_in       = trade_go ? req_tdata[SYM_W +: PRICE_W] : s1_price_ff;
      s1_size_in        = trade_go ? req_tdata[SYM_W+PRICE_W +: SIZE_W] : s1_size_ff;
      rsp_valid_in      = rsp_tready ? 1'b0 : rsp_valid_ff;
      rsp_last_in       = rsp_last_ff;
      rsp_data_in       = rsp_data_ff;
      case (state_ff)
         ST_IDLE: begin
            if (report_go && walk_n != '0) begin
               walk_in  = '0;
               state_in = ST_READ;
            end
         end
         ST_READ: begin
            if (rsp_free) begin
               state_in = ST_LOAD;
            end
         end
         ST_LOAD: begin
            rsp_valid_in = 1'b1;
            rsp_last_in  = walk_last;
            rsp_data_in  = {(RSP_W - SYM_W - 2*VOL_W - 3*CNT_W)'(0),
                            rd_data.reversals, rd_data.tick_count,
                            rd_data.trade_count, rd_data.tick_volume,
                            rd_data.volume, walk_ff[SYM_W-1:0]};
            walk_in      = walk_next;
            state_in     = walk_last ? ST_IDLE : ST_READ;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff          <= ST_IDLE;
         walk_ff           <= '0;
         symbols_in_use_ff <= SYMBOLS_IN_USE_RESET;
         s1_trade_ff       <= 1'b0;
         rsp_valid_ff      <= 1'b0;
      end else begin
         state_ff          <= state_in;
         walk_ff           <= walk_in;
         symbols_in_use_ff <= symbols_in_use_in;
         s1_trade_ff       <= s1_trade_in;
         rsp_valid_ff      <= rsp_valid_in;
      end
      s1_addr_ff  <= s1_addr_in;
      s1_price_ff <= s1_price_in;
      s1_size_ff  <= s1_size_in;
      rsp_last_ff <= rsp_last_in;
      rsp_data_ff <= rsp_data_in;
   end

   a_no_write_clash: assert property (@(posedge clock) disable iff (reset)
      !(s1_trade_ff && state_ff == ST_LOAD))
      else $error("trade write-back collides with report clear");

   a_load_slot_free: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_LOAD |-> !rsp_valid_ff)
      else $error("report result would overwrite a waiting item");

   a_load_shows: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_LOAD |=> rsp_valid_ff)
      else $error("report entry loaded but no item presented");

   a_walk_bound: assert property (@(posedge clock) disable iff (reset)
      state_ff != ST_IDLE |-> walk_ff < walk_n)
      else $error("report walk beyond table");

endmodule
